### design/uhe_pkg.sv
package uhe_pkg;

  localparam int unsigned EDGE_W      = 32;
  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned BWIDTH_W    = 31;
  localparam int unsigned BCOUNT_W    = 13;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned TOTAL_W     = 64;
  localparam int unsigned QUO_W       = (SAMPLE_BITS > EDGE_W) ? SAMPLE_BITS : EDGE_W;
  localparam int unsigned OP_W        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_EDGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 3'd3;

  localparam logic signed [EDGE_W-1:0] LOW_EDGE_RST  = 32'sd0;
  localparam logic signed [EDGE_W-1:0] HIGH_EDGE_RST = 32'sd4096;
  localparam logic [BWIDTH_W-1:0]      BIN_WIDTH_RST = 31'd1;
  localparam logic [BCOUNT_W-1:0]      BIN_COUNT_RST = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    logic                start;
    logic [QUO_W-1:0]    dividend;
    logic [BWIDTH_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/uhe_in_if.sv
interface uhe_in_if #(
  parameter int unsigned IDX_W       = 13
);
  logic                                   valid;
  logic                                   ready;
  logic [uhe_pkg::OP_W-1:0]               opcode;
  logic signed [uhe_pkg::SAMPLE_BITS-1:0] sample;
  logic [IDX_W-1:0]                       bin_index;

  modport source (output valid, output opcode, output sample, output bin_index, input ready);
  modport sink (input valid, input opcode, input sample, input bin_index, output ready);
endinterface

### design/uhe_out_if.sv
interface uhe_out_if #(
  parameter int unsigned IDX_W = 13
);
  logic                         valid;
  logic                         ready;
  logic [IDX_W-1:0]             bin_number;
  logic [uhe_pkg::VALUE_W-1:0]  bin_value;
  logic [uhe_pkg::TOTAL_W-1:0]  total_seen;
  logic [uhe_pkg::TOTAL_W-1:0]  total_in_range;
  logic                         was_in_range;

  modport source (output valid, output bin_number, output bin_value, output total_seen,
                  output total_in_range, output was_in_range, input ready);
  modport sink (input valid, input bin_number, input bin_value, input total_seen,
                input total_in_range, input was_in_range, output ready);
endinterface

### design/uhe_div.sv
module uhe_div (
  input  logic              clk,
  input  logic              rst_n,
  input  uhe_pkg::div_req_t req,
  output uhe_pkg::div_rsp_t rsp
);
  localparam int unsigned QW    = uhe_pkg::QUO_W;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QW - 1);

  logic [QW-1:0]                   rem_r;
  logic [QW-1:0]                   quo_r;
  logic [uhe_pkg::BWIDTH_W-1:0]    dvs_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [QW-1:0]                   trial;
  logic [QW-1:0]                   dvs_ext;
  logic                            fits;

  assign trial   = {rem_r[QW-2:0], quo_r[QW-1]};
  assign dvs_ext = QW'(dvs_r);
  assign fits    = trial >= dvs_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? trial - dvs_ext : trial;
        quo_r <= {quo_r[QW-2:0], fits};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

### design/uhe_store.sv
module uhe_store #(
  parameter int unsigned DEPTH = 4098,
  parameter int unsigned AW    = 13
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [uhe_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [uhe_pkg::VALUE_W-1:0] rdata
);
  logic [uhe_pkg::VALUE_W-1:0] mem_r [0:DEPTH-1];
  logic [uhe_pkg::VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

### design/uniform_histogram_engine_top.sv
// Uniform-bin histogram with underflow and overflow bins.
// in_ch carries one command per transfer: count a sample, read a bin, or clear.
// out_ch returns exactly one result per command, in command order.
// cfg_we/cfg_index/cfg_wdata write low_edge, high_edge, bin_width, bin_count;
// write them only while no command is in flight.
// A count of an in-range sample takes its bin index from a restoring divider
// that retires one quotient bit per cycle; the bin counter then does a
// read-modify-write on the bin memory. The next command is taken once the
// result has been loaded into the output register.
// Counts outside the regular range and reads skip the divider.
// The unused opcode goes straight to the output without touching the memory.
// A clear sweeps the bin memory one entry per cycle over MAX_BINS+2 entries,
// then returns its result through the output register.
// After reset the same sweep runs; in_ch.ready stays low until it ends.
// Config writes are taken at any time.
// in_ch.ready is high only between commands. A finished result sits in an
// output register, so the next command is taken while out_ch is stalled;
// that command then holds its result until the register drains.
module uniform_histogram_engine_top #(
  parameter int unsigned MAX_BINS    = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  uhe_in_if.sink                           in_ch,
  uhe_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [uhe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uhe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  localparam int unsigned DEPTH = MAX_BINS + 2;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CMP_W = (uhe_pkg::SAMPLE_BITS > uhe_pkg::EDGE_W)
                                  ? uhe_pkg::SAMPLE_BITS : uhe_pkg::EDGE_W;
  localparam int unsigned VW    = uhe_pkg::VALUE_W;
  localparam int unsigned TW    = uhe_pkg::TOTAL_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WB,
    ST_OUT
  } state_t;

  logic signed [uhe_pkg::EDGE_W-1:0] low_edge_r;
  logic signed [uhe_pkg::EDGE_W-1:0] high_edge_r;
  logic [uhe_pkg::BWIDTH_W-1:0]      bin_width_r;
  logic [uhe_pkg::BCOUNT_W-1:0]      bin_count_r;

  state_t           state_r;
  logic [IDX_W-1:0] clr_addr_r;
  logic             clr_pend_r;
  logic [uhe_pkg::OP_W-1:0] op_r;
  logic [IDX_W-1:0] bnum_r;
  logic [VW-1:0]    bval_r;
  logic             inrange_r;
  logic             rd_ok_r;
  logic [TW-1:0]    seen_r;
  logic [TW-1:0]    range_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_bnum_r;
  logic [VW-1:0]    out_bval_r;
  logic [TW-1:0]    out_seen_r;
  logic [TW-1:0]    out_range_r;
  logic             out_inr_r;

  logic [IDX_W-1:0]         n_bins;
  logic signed [CMP_W-1:0]  s_ext;
  logic signed [CMP_W-1:0]  lo_ext;
  logic signed [CMP_W-1:0]  hi_ext;
  logic signed [CMP_W-1:0]  diff;
  logic                     below;
  logic                     above;
  logic                     accept;
  logic                     out_load;

  uhe_pkg::div_req_t div_req;
  uhe_pkg::div_rsp_t div_rsp;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VW-1:0]    mem_wdata;
  logic [VW-1:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_edge_r  <= uhe_pkg::LOW_EDGE_RST;
      high_edge_r <= uhe_pkg::HIGH_EDGE_RST;
      bin_width_r <= uhe_pkg::BIN_WIDTH_RST;
      bin_count_r <= uhe_pkg::BIN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        uhe_pkg::CFG_LOW_EDGE:  low_edge_r  <= cfg_wdata;
        uhe_pkg::CFG_HIGH_EDGE: high_edge_r <= cfg_wdata;
        uhe_pkg::CFG_BIN_WIDTH: bin_width_r <= cfg_wdata[uhe_pkg::BWIDTH_W-1:0];
        uhe_pkg::CFG_BIN_COUNT: bin_count_r <= cfg_wdata[uhe_pkg::BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bin_count_r == '0) begin
      n_bins = IDX_W'(1);
    end else if (32'(bin_count_r) > 32'(MAX_BINS)) begin
      n_bins = IDX_W'(MAX_BINS);
    end else begin
      n_bins = IDX_W'(bin_count_r);
    end
  end

  assign s_ext  = CMP_W'(in_ch.sample);
  assign lo_ext = CMP_W'(low_edge_r);
  assign hi_ext = CMP_W'(high_edge_r);
  assign diff   = s_ext - lo_ext;
  assign below  = s_ext < lo_ext;
  assign above  = s_ext >= hi_ext;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  assign div_req.start    = accept && (in_ch.opcode == uhe_pkg::OP_COUNT) && !below && !above;
  assign div_req.dividend = diff[uhe_pkg::QUO_W-1:0];
  assign div_req.divisor  = (bin_width_r == '0) ? uhe_pkg::BWIDTH_W'(1) : bin_width_r;

  uhe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign mem_we    = (state_r == ST_CLEAR) ||
                     ((state_r == ST_WB) && (op_r == uhe_pkg::OP_COUNT));
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : bnum_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : mem_rdata + VW'(1);

  uhe_store #(
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (bnum_r),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      range_r     <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          if (clr_addr_r == IDX_W'(DEPTH - 1)) begin
            clr_addr_r <= '0;
            clr_pend_r <= 1'b0;
            state_r    <= clr_pend_r ? ST_OUT : ST_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            op_r      <= in_ch.opcode;
            inrange_r <= (in_ch.opcode == uhe_pkg::OP_COUNT) && !below && !above;
            bval_r    <= '0;
            case (in_ch.opcode)
              uhe_pkg::OP_COUNT: begin
                if (below) begin
                  bnum_r  <= '0;
                  state_r <= ST_RD;
                end else if (above) begin
                  bnum_r  <= n_bins + IDX_W'(1);
                  state_r <= ST_RD;
                end else begin
                  state_r   <= ST_DIV;
                end
              end
              uhe_pkg::OP_READ: begin
                bnum_r  <= in_ch.bin_index;
                rd_ok_r <= in_ch.bin_index <= (n_bins + IDX_W'(1));
                state_r <= ST_RD;
              end
              uhe_pkg::OP_CLEAR: begin
                bnum_r     <= '0;
                seen_r     <= '0;
                range_r    <= '0;
                clr_addr_r <= '0;
                clr_pend_r <= 1'b1;
                state_r    <= ST_CLEAR;
              end
              default: begin
                bnum_r  <= '0;
                state_r <= ST_OUT;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient >= uhe_pkg::QUO_W'(n_bins)) begin
              bnum_r <= n_bins;
            end else begin
              bnum_r <= div_rsp.quotient[IDX_W-1:0] + IDX_W'(1);
            end
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          state_r <= ST_WB;
        end
        ST_WB: begin
          if (op_r == uhe_pkg::OP_COUNT) begin
            bval_r <= mem_rdata + VW'(1);
            seen_r <= seen_r + TW'(1);
            if (inrange_r) begin
              range_r <= range_r + TW'(1);
            end
          end else begin
            bval_r <= rd_ok_r ? mem_rdata : '0;
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_bnum_r  <= bnum_r;
            out_bval_r  <= bval_r;
            out_seen_r  <= seen_r;
            out_range_r <= range_r;
            out_inr_r   <= inrange_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.bin_number     = out_bnum_r;
  assign out_ch.bin_value      = out_bval_r;
  assign out_ch.total_seen     = out_seen_r;
  assign out_ch.total_in_range = out_range_r;
  assign out_ch.was_in_range   = out_inr_r;
endmodule
